// ===== rtl/pftl_pkg.sv =====
// Shared types and constants of the pump flow trim loop.
`timescale 1ns / 1ps
package pftl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FLOW_SETPOINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_LITRE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_PER_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_ENABLE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_GAIN        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_LIMIT       = 3'd5;

  localparam int DIV_NUM_W = 80;
  localparam int DIV_DEN_W = 45;
  localparam int DIV_Q_W   = 32;

  localparam logic [47:0] FLOW_SCALE   = 48'd96000000000000;
  localparam logic [31:0] FLOW_SAT     = 32'h7FFF_FFFF;
  localparam logic [31:0] TRIM_CAP     = 32'd1048576;
  localparam logic [17:0] TRIM_ONE     = 18'd65536;
  localparam logic [31:0] SP_TO_HZ     = 32'd500;
  localparam logic [31:0] PERIOD_SCALE = 32'd6000000;
  localparam logic [31:0] SP_SCALE     = 32'd1000000;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL_LO, OP_MUL_HI, OP_MUL_ADD, OP_F_DEN, OP_DIV_GO,
    OP_F_FIN, OP_T_ERR, OP_T_XG, OP_T_SET, OP_T_DEN, OP_T_FIN, OP_P_A,
    OP_P_B, OP_P_CMP, OP_P_NUM, OP_P_N2, OP_P_FIN, OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_F_LO, ST_F_HI, ST_F_ADD, ST_F_DEN, ST_F_GO, ST_F_WAIT,
    ST_F_FIN, ST_CHK, ST_T_ERR, ST_T_XG, ST_T_SET, ST_T_LO, ST_T_HI, ST_T_ADD,
    ST_T_DEN, ST_T_GO, ST_T_WAIT, ST_T_FIN, ST_P_A, ST_P_B, ST_P_CMP, ST_P_NUM,
    ST_P_N2, ST_P_GO, ST_P_WAIT, ST_P_FIN, ST_OUT
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic do_flow;
    logic trim_go;
    logic per_path;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/pftl_if.sv =====
// Valid/ready channels for ticks and results.
`timescale 1ns / 1ps
interface pftl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pulse_count;
  logic               count_ok;
  logic [23:0]        tick_us;
  modport source (output valid, pulse_count, count_ok, tick_us, input ready);
  modport sink (input valid, pulse_count, count_ok, tick_us, output ready);
endinterface

interface pftl_out_if;
  logic               valid;
  logic               ready;
  logic [29:0]        step_period_ns;
  logic signed [31:0] measured_flow;
  logic               flow_valid;
  logic [17:0]        trim_factor;
  modport source (output valid, step_period_ns, measured_flow, flow_valid, trim_factor,
                  input ready);
  modport sink (input valid, step_period_ns, measured_flow, flow_valid, trim_factor,
                output ready);
endinterface

// ===== rtl/pump_flow_trim_loop_unit.sv =====
// A tick with no flow and a stopped pump goes from transfer through dispatch straight
// to the result; a tick with flow, trim and period runs up to three divisions, each
// on the shared one-bit-per-cycle divider.
// Throughput: one tick in flight; the next is taken once the result sits in the
// output register. Reset (rst, synchronous) loads register defaults, trim to one
// and clears the primed flag and the previous count.
`timescale 1ns / 1ps
module pump_flow_trim_loop_unit
  import pftl_pkg::*;
#(
  parameter int MAX_FLOW = 200000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pftl_in_if.sink               item_in,
  pftl_out_if.source            result_out
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pftl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pftl_dp #(
    .MAX_FLOW (MAX_FLOW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .pulse_count (item_in.pulse_count),
    .count_ok    (item_in.count_ok),
    .tick_us     (item_in.tick_us),
    .result_out  (result_out)
  );

endmodule

// ===== rtl/pftl_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, with quotient overflow flag.
`timescale 1ns / 1ps
module pftl_div
  import pftl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_Q_W-1:0]   quo,
  output logic                 ovf
);

  logic                 busy;
  logic [6:0]           step;
  logic [DIV_NUM_W-1:0] nsh;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W+1:0] diff;
  logic                 ge;

  assign trial = {rem, nsh[DIV_NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den};
  assign ge    = ~diff[DIV_DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (step == 7'd0);
      if (start) begin
        busy <= 1'b1;
        step <= 7'(DIV_NUM_W - 1);
      end else if (busy) begin
        if (step == 7'd0) begin
          busy <= 1'b0;
        end else begin
          step <= step - 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh <= num;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      nsh <= {nsh[DIV_NUM_W-2:0], 1'b0};
      rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      // a set top bit means the next shift passes the quotient width
      ovf <= ovf | quo[DIV_Q_W-1];
      quo <= {quo[DIV_Q_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/pftl_dp.sv =====
// Datapath: config registers, shared multiplier, divider, trim state and result register.
`timescale 1ns / 1ps
module pftl_dp
  import pftl_pkg::*;
#(
  parameter int MAX_FLOW = 200000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [31:0]           pulse_count,
  input  logic                  count_ok,
  input  logic [23:0]           tick_us,
  pftl_out_if.source            result_out
);

  logic [17:0] sp;
  logic [19:0] ppl;
  logic [23:0] vps;
  logic        pump;
  logic [15:0] gain;
  logic [15:0] lim;

  logic [31:0] prev;
  logic        primed;
  logic [17:0] trim;

  logic [23:0] dt;
  logic        neg;
  logic        do_flow;
  logic [31:0] flow;
  logic        valid_r;
  logic [31:0] emag;
  logic        eneg;
  logic [47:0] xw;
  logic [31:0] yw;
  logic [63:0] p;
  logic [79:0] num;
  logic        go;
  logic [29:0] period;
  logic        out_v;

  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [31:0] d, mag;
  logic [32:0] err;
  logic [31:0] qflow, qinc;
  logic [22:0] tbase, tsum, lob, hib, tclamp;
  logic [43:0] rhs;
  logic        div_done;
  logic [31:0] quo;
  logic        ovf;
  logic        good_read;

  assign d   = pulse_count - prev;
  assign mag = d[31] ? (32'd0 - d) : d;
  assign err = {15'd0, sp} - {flow[31], flow};
  assign good_read = (tick_us != '0) && count_ok;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_MUL_LO: begin ma = xw[31:0];            mb = yw;             end
      OP_MUL_HI: begin ma = {16'd0, xw[47:32]};  mb = yw;             end
      OP_F_DEN:  begin ma = {8'd0, dt};          mb = {12'd0, ppl};   end
      OP_T_XG:   begin ma = emag;                mb = {16'd0, gain};  end
      OP_T_DEN:  begin ma = {14'd0, sp};         mb = SP_SCALE;       end
      OP_P_A:    begin ma = {14'd0, sp};         mb = SP_TO_HZ;       end
      OP_P_B:    begin ma = p[31:0];             mb = {14'd0, trim};  end
      OP_P_NUM:  begin ma = {8'd0, vps};         mb = PERIOD_SCALE;   end
      OP_P_N2:   begin ma = {14'd0, sp};         mb = {14'd0, trim};  end
      default:   begin ma = '0;                  mb = '0;             end
    endcase
  end

  assign prod = {32'd0, ma} * {32'd0, mb};

  assign qflow = (ovf || quo > FLOW_SAT) ? FLOW_SAT : quo;
  assign qinc  = (ovf || quo > TRIM_CAP) ? TRIM_CAP : quo;
  assign tbase = {5'd0, trim};
  assign tsum  = eneg ? (tbase - qinc[22:0]) : (tbase + qinc[22:0]);
  assign lob   = {5'd0, TRIM_ONE} - {7'd0, lim};
  assign hib   = {5'd0, TRIM_ONE} + {7'd0, lim};

  // clamp the signed sum into one plus or minus the limit
  always_comb begin
    priority if ($signed(tsum) < $signed(lob)) tclamp = lob;
    else if ($signed(tsum) > $signed(hib)) tclamp = hib;
    else tclamp = tsum;
  end

  assign rhs = {2'd0, ({2'd0, vps} + {1'b0, vps, 1'b0}), 16'd0};

  pftl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_DIV_GO),
    .num   (num),
    .den   (p[DIV_DEN_W-1:0]),
    .done  (div_done),
    .quo   (quo),
    .ovf   (ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sp      <= '0;
      ppl     <= 20'd96000;
      vps     <= 24'd1830;
      pump    <= 1'b0;
      gain    <= 16'd1311;
      lim     <= 16'd22938;
      prev    <= '0;
      primed  <= 1'b0;
      trim    <= TRIM_ONE;
      do_flow <= 1'b0;
      valid_r <= 1'b0;
      out_v   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_FLOW_SETPOINT: begin
            sp   <= ({2'd0, cfg_data[17:0]} > 20'(MAX_FLOW)) ? 18'(MAX_FLOW)
                                                              : cfg_data[17:0];
            trim <= TRIM_ONE;
          end
          REG_PULSES_PER_LITRE: if (cfg_data[19:0] > 20'd16) ppl <= cfg_data[19:0];
          REG_VOLUME_PER_STEP:  if (cfg_data != '0) vps <= cfg_data;
          REG_PUMP_ENABLE:      pump <= cfg_data[0];
          REG_TRIM_GAIN:        gain <= cfg_data[15:0];
          REG_TRIM_LIMIT:       lim <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD) begin
        valid_r <= 1'b0;
        do_flow <= good_read && primed;
        if (good_read) begin
          prev   <= pulse_count;
          primed <= 1'b1;
        end
      end
      if (cmd.op == OP_F_FIN) valid_r <= 1'b1;
      if (cmd.op == OP_T_FIN) trim <= tclamp[17:0];
      if (cmd.op == OP_OUT) out_v <= 1'b1;
      else if (result_out.ready) out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        dt     <= tick_us;
        neg    <= d[31];
        xw     <= FLOW_SCALE;
        yw     <= mag;
        flow   <= '0;
        period <= '0;
      end
      OP_MUL_LO, OP_F_DEN, OP_T_XG, OP_T_DEN, OP_P_A, OP_P_B, OP_P_NUM: p <= prod;
      OP_MUL_HI: begin
        num <= {16'd0, p};
        p   <= prod;
      end
      OP_MUL_ADD: num <= num + {p[47:0], 32'd0};
      OP_F_FIN:   flow <= neg ? (32'd0 - qflow) : qflow;
      OP_T_ERR: begin
        eneg <= err[32];
        emag <= err[32] ? (32'd0 - err[31:0]) : err[31:0];
      end
      OP_T_SET: begin
        xw <= p[47:0];
        yw <= {8'd0, dt};
      end
      OP_P_CMP: go <= (p[43:0] >= rhs);
      OP_P_N2: begin
        num <= {p[63:0], 16'd0};
        p   <= prod;
      end
      OP_P_FIN: period <= go ? quo[29:0] : '0;
      OP_OUT: begin
        result_out.step_period_ns <= period;
        result_out.measured_flow  <= flow;
        result_out.flow_valid     <= valid_r;
        result_out.trim_factor    <= trim;
      end
      default: ;
    endcase
  end

  assign result_out.valid = out_v;

  assign stat.do_flow  = do_flow;
  assign stat.per_path = pump && (sp != '0);
  assign stat.trim_go  = pump && (sp != '0) && valid_r && ($signed(flow) > 32'sd50);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_v || result_out.ready;

endmodule

// ===== rtl/pftl_ctrl.sv =====
// Controller: sequences flow, trim and period steps of one tick.
`timescale 1ns / 1ps
module pftl_ctrl
  import pftl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DISP;
      ST_DISP: begin
        priority if (stat.do_flow) state_next = ST_F_LO;
        else if (stat.per_path) state_next = ST_P_A;
        else state_next = ST_OUT;
      end
      ST_F_LO:   state_next = ST_F_HI;
      ST_F_HI:   state_next = ST_F_ADD;
      ST_F_ADD:  state_next = ST_F_DEN;
      ST_F_DEN:  state_next = ST_F_GO;
      ST_F_GO:   state_next = ST_F_WAIT;
      ST_F_WAIT: if (stat.div_done) state_next = ST_F_FIN;
      ST_F_FIN:  state_next = ST_CHK;
      ST_CHK: begin
        priority if (stat.trim_go) state_next = ST_T_ERR;
        else if (stat.per_path) state_next = ST_P_A;
        else state_next = ST_OUT;
      end
      ST_T_ERR:  state_next = ST_T_XG;
      ST_T_XG:   state_next = ST_T_SET;
      ST_T_SET:  state_next = ST_T_LO;
      ST_T_LO:   state_next = ST_T_HI;
      ST_T_HI:   state_next = ST_T_ADD;
      ST_T_ADD:  state_next = ST_T_DEN;
      ST_T_DEN:  state_next = ST_T_GO;
      ST_T_GO:   state_next = ST_T_WAIT;
      ST_T_WAIT: if (stat.div_done) state_next = ST_T_FIN;
      ST_T_FIN:  state_next = ST_P_A;
      ST_P_A:    state_next = ST_P_B;
      ST_P_B:    state_next = ST_P_CMP;
      ST_P_CMP:  state_next = ST_P_NUM;
      ST_P_NUM:  state_next = ST_P_N2;
      ST_P_N2:   state_next = ST_P_GO;
      ST_P_GO:   state_next = ST_P_WAIT;
      ST_P_WAIT: if (stat.div_done) state_next = ST_P_FIN;
      ST_P_FIN:  state_next = ST_OUT;
      ST_OUT:    if (stat.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_F_LO, ST_T_LO:   cmd.op = OP_MUL_LO;
      ST_F_HI, ST_T_HI:   cmd.op = OP_MUL_HI;
      ST_F_ADD, ST_T_ADD: cmd.op = OP_MUL_ADD;
      ST_F_DEN:           cmd.op = OP_F_DEN;
      ST_F_GO, ST_T_GO, ST_P_GO: cmd.op = OP_DIV_GO;
      ST_F_FIN:           cmd.op = OP_F_FIN;
      ST_T_ERR:           cmd.op = OP_T_ERR;
      ST_T_XG:            cmd.op = OP_T_XG;
      ST_T_SET:           cmd.op = OP_T_SET;
      ST_T_DEN:           cmd.op = OP_T_DEN;
      ST_T_FIN:           cmd.op = OP_T_FIN;
      ST_P_A:             cmd.op = OP_P_A;
      ST_P_B:             cmd.op = OP_P_B;
      ST_P_CMP:           cmd.op = OP_P_CMP;
      ST_P_NUM:           cmd.op = OP_P_NUM;
      ST_P_N2:            cmd.op = OP_P_N2;
      ST_P_FIN:           cmd.op = OP_P_FIN;
      ST_OUT:             if (stat.out_free) cmd.op = OP_OUT;
      default:            cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== sim/pump_flow_trim_loop_unit_test.sv =====
// Self-checking bench for the pump flow trim loop: directed ticks, then random ticks.
`timescale 1ns / 1ps
module pump_flow_trim_loop_unit_test;
  import pftl_pkg::*;

  localparam int MAX_FLOW_TB = 200000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic signed [31:0] count;
    logic               ok;
    logic [23:0]        dt;
    logic               has_exp;
    logic [29:0]        period;
    logic signed [31:0] flow;
    logic               fvalid;
    logic [17:0]        trim;
  } tick_row_t;

  typedef struct {
    logic [29:0]        period;
    logic signed [31:0] flow;
    logic               fvalid;
    logic [17:0]        trim;
  } pump_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  pftl_in_if  tick_ch ();
  pftl_out_if res_ch ();

  pump_flow_trim_loop_unit #(.MAX_FLOW(MAX_FLOW_TB)) u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .item_in(tick_ch.sink), .result_out(res_ch.source)
  );

  // predictor copy of registers and state
  logic [17:0] m_setpoint;
  logic [19:0] m_k;
  logic [23:0] m_vps;
  logic        m_en;
  logic [15:0] m_gain;
  logic [15:0] m_limit;
  logic [31:0] m_prev;
  logic        m_primed;
  longint      m_trim;

  pump_result_t expected_q[$];
  int  fail_count;
  int  idle_cycles;
  bit  rx_stall_long;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void model_reset();
    m_setpoint = '0;
    m_k = 20'd96000;
    m_vps = 24'd1830;
    m_en = 1'b0;
    m_gain = 16'd1311;
    m_limit = 16'd22938;
    m_prev = '0;
    m_primed = 1'b0;
    m_trim = 65536;
  endfunction

  function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_FLOW_SETPOINT: begin
        m_setpoint = (v[17:0] > MAX_FLOW_TB) ? 18'(MAX_FLOW_TB) : v[17:0];
        m_trim = 65536;
      end
      REG_PULSES_PER_LITRE: if (v[19:0] > 16) m_k = v[19:0];
      REG_VOLUME_PER_STEP: if (v != 0) m_vps = v;
      REG_PUMP_ENABLE: m_en = v[0];
      REG_TRIM_GAIN: m_gain = v[15:0];
      REG_TRIM_LIMIT: m_limit = v[15:0];
      default: ;
    endcase
  endfunction

  function automatic pump_result_t predict_tick(logic [31:0] count, logic ok, logic [23:0] dt);
    pump_result_t r;
    logic [31:0] d;
    logic [31:0] mag;
    logic        neg;
    logic [127:0] q;
    logic [127:0] inc;
    longint flow;
    longint err;
    longint lo_b;
    longint hi_b;
    logic [127:0] lhs;
    logic [127:0] rhs;
    r.period = '0;
    r.fvalid = 1'b0;
    flow = 0;
    if (dt != 0 && ok) begin
      if (!m_primed) begin
        m_prev = count;
        m_primed = 1'b1;
      end else begin
        d = count - m_prev;
        neg = d[31];
        mag = neg ? -d : d;
        m_prev = count;
        q = (128'd96000000000000 * mag) / (128'(dt) * m_k);
        if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        flow = neg ? -longint'(q) : longint'(q);
        r.fvalid = 1'b1;
      end
    end
    if (m_en && m_setpoint > 0) begin
      if (r.fvalid && flow > 50) begin
        err = longint'(m_setpoint) - flow;
        inc = (128'(err < 0 ? -err : err) * m_gain * dt) / (128'(m_setpoint) * 1000000);
        if (inc > 128'd1048576) inc = 128'd1048576;
        m_trim += (err < 0) ? -longint'(inc) : longint'(inc);
        lo_b = 65536 - longint'(m_limit);
        hi_b = 65536 + longint'(m_limit);
        if (m_trim < lo_b) m_trim = lo_b;
        if (m_trim > hi_b) m_trim = hi_b;
      end
      lhs = 128'(m_setpoint) * 500 * m_trim;
      rhs = 128'(m_vps) * 3 * 65536;
      if (lhs >= rhs && m_trim > 0)
        r.period = 30'((128'd6000000 * m_vps * 65536) / (128'(m_setpoint) * m_trim));
    end
    r.flow = 32'(flow);
    r.trim = 18'(m_trim);
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // sink side: random ready when long stalls are on, else always ready; check at rising edge
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_stall_long ? gap_len() : 0;
      res_ch.ready = (stall == 0);
      @(negedge clk);
      if (stall > 0) begin
        repeat (stall - 1) @(negedge clk);
        res_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pump_result_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: period %0d flow %0d", res_ch.step_period_ns,
               res_ch.measured_flow);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (res_ch.step_period_ns !== e.period) begin
          $error("step_period_ns expected %0d actual %0d", e.period, res_ch.step_period_ns);
          fail_count++;
        end
        if (res_ch.measured_flow !== e.flow) begin
          $error("measured_flow expected %0d actual %0d", e.flow, res_ch.measured_flow);
          fail_count++;
        end
        if (res_ch.flow_valid !== e.fvalid) begin
          $error("flow_valid expected %0d actual %0d", e.fvalid, res_ch.flow_valid);
          fail_count++;
        end
        if (res_ch.trim_factor !== e.trim) begin
          $error("trim_factor expected %0d actual %0d", e.trim, res_ch.trim_factor);
          fail_count++;
        end
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    model_write(idx, v);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // drive one tick; expected pushed at the transfer edge
  task automatic send_tick(logic [31:0] count, logic ok, logic [23:0] dt, bit use_gap);
    int g;
    g = use_gap ? gap_len() : 0;
    repeat (g) @(negedge clk);
    tick_ch.valid = 1'b1;
    tick_ch.pulse_count = count;
    tick_ch.count_ok = ok;
    tick_ch.tick_us = dt;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    expected_q.push_back(predict_tick(count, ok, dt));
    @(negedge clk);
    tick_ch.valid = 1'b0;
  endtask

  task automatic run_table();
    tick_row_t rows[$];
    pump_result_t r;
    // reset state: stopped pump, trim one
    rows.push_back('{32'sd1000, 1'b0, 24'd5000, 1'b1, 30'd0, 32'sd0, 1'b0, 18'd65536});
    rows.push_back('{32'sd1000, 1'b1, 24'd0, 1'b1, 30'd0, 32'sd0, 1'b0, 18'd65536});
    // first good read only primes
    rows.push_back('{32'sd1000, 1'b1, 24'd5000, 1'b1, 30'd0, 32'sd0, 1'b0, 18'd65536});
    // zero delta
    rows.push_back('{32'sd1000, 1'b1, 24'd5000, 1'b1, 30'd0, 32'sd0, 1'b1, 18'd65536});
    rows.push_back('{32'sd1100, 1'b1, 24'd5000, 1'b0, '0, '0, '0, '0});
    rows.push_back('{32'sd900, 1'b1, 24'd1, 1'b0, '0, '0, '0, '0});
    // wrap across the most negative value, saturating flow
    rows.push_back('{32'h7FFF_FFFF, 1'b1, 24'hFF_FFFF, 1'b0, '0, '0, '0, '0});
    rows.push_back('{32'h8000_0000, 1'b1, 24'hFF_FFFF, 1'b0, '0, '0, '0, '0});
    rows.push_back('{32'h0000_0000, 1'b1, 24'd1, 1'b0, '0, '0, '0, '0});
    rows.push_back('{32'h8000_0000, 1'b1, 24'd1, 1'b0, '0, '0, '0, '0});
    rows.push_back('{32'h0000_0000, 1'b0, 24'd1, 1'b0, '0, '0, '0, '0});
    foreach (rows[i]) begin
      send_tick(rows[i].count, rows[i].ok, rows[i].dt, 1'b1);
      if (rows[i].has_exp) begin
        r = expected_q[$];
        if (r.period !== rows[i].period || r.flow !== rows[i].flow ||
            r.fvalid !== rows[i].fvalid || r.trim !== rows[i].trim) begin
          $error("table row %0d: predictor disagrees with typed result", i);
          fail_count++;
        end
      end
    end
  endtask

  // well-formed running counter with a random flow, some noise
  task automatic random_phase(int n);
    logic [31:0] cnt;
    logic [23:0] dt;
    int p;
    cnt = $urandom;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 70) dt = 24'($urandom_range(1000, 20000));
      else if (p < 80) dt = 24'($urandom_range(1, 50));
      else if (p < 85) dt = 24'(0);
      else dt = 24'($urandom);
      p = $urandom_range(0, 99);
      if (p < 75) cnt = cnt + $urandom_range(0, 400);
      else if (p < 85) cnt = cnt - $urandom_range(0, 400);
      else cnt = $urandom;
      send_tick(cnt, ($urandom_range(0, 9) != 0), dt, 1'b1);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] v;
    fail_count = 0;
    rx_stall_long = 1'b1;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = REG_FLOW_SETPOINT;
    cfg_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.pulse_count = '0;
    tick_ch.count_ok = 1'b0;
    tick_ch.tick_us = '0;
    model_reset();
    repeat (4) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    run_table();
    wait_drained();

    // nominal running pump
    write_reg(REG_PUMP_ENABLE, 24'd1);
    write_reg(REG_FLOW_SETPOINT, 24'd6000);
    write_reg(REG_PULSES_PER_LITRE, 24'd16);
    write_reg(REG_VOLUME_PER_STEP, 24'd0);
    send_tick(32'sd1000, 1'b1, 24'd10000, 1'b0);
    send_tick(32'sd1000, 1'b1, 24'd10000, 1'b0);
    wait_drained();
    random_phase(200);
    wait_drained();

    // extremes
    write_reg(REG_FLOW_SETPOINT, 24'h3FFFF);
    write_reg(REG_PULSES_PER_LITRE, 24'hFFFFF);
    write_reg(REG_VOLUME_PER_STEP, 24'hFFFFFF);
    write_reg(REG_TRIM_GAIN, 24'hFFFF);
    write_reg(REG_TRIM_LIMIT, 24'hFFFF);
    random_phase(150);
    wait_drained();

    write_reg(REG_FLOW_SETPOINT, 24'd1);
    write_reg(REG_PULSES_PER_LITRE, 24'd17);
    write_reg(REG_VOLUME_PER_STEP, 24'd1);
    write_reg(REG_TRIM_GAIN, 24'd0);
    write_reg(REG_TRIM_LIMIT, 24'd0);
    random_phase(150);
    wait_drained();

    // random settings, alternating phases with long stalls and with no sink stalls
    for (int ph = 0; ph < 6; ph++) begin
      rx_stall_long = (ph % 2 == 0);
      v = 24'($urandom_range(50, 200000));
      write_reg(REG_FLOW_SETPOINT, ph == 5 ? 24'(0) : v);
      write_reg(REG_PULSES_PER_LITRE, 24'($urandom_range(17, 1048575)));
      write_reg(REG_VOLUME_PER_STEP, 24'($urandom_range(1, 20000)));
      write_reg(REG_PUMP_ENABLE, ph == 4 ? 24'(0) : 24'(1));
      write_reg(REG_TRIM_GAIN, 24'($urandom_range(0, 65535)));
      write_reg(REG_TRIM_LIMIT, 24'($urandom_range(0, 65535)));
      random_phase(100);
      wait_drained();
    end
    rx_stall_long = 1'b1;
    write_reg(REG_PUMP_ENABLE, 24'd1);
    write_reg(REG_FLOW_SETPOINT, 24'd6000);
    write_reg(REG_PULSES_PER_LITRE, 24'd96000);
    random_phase(40);
    wait_drained();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
